FILE: sv/pbam_pkg.sv
// ----------------------------------------------------------------------------
// pbam_pkg
// shared constants and types of the mosaic tile averager
// ----------------------------------------------------------------------------
package pbam_pkg;

   localparam int MAX_WIDTH   = 2048;
   localparam int MAX_TILE    = 64;
   localparam int SLOT_BITS   = $clog2(MAX_WIDTH);
   localparam int SUM_BITS    = 20;
   localparam int CHAN_BITS   = 8;
   localparam int COUNT_BITS  = 13;
   localparam int REM_BITS    = 13;
   localparam int STEP_BITS   = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   localparam logic [1:0]  CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0]  CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0]  CSR_BLOCK_SIZE   = 2'd2;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [11:0] HEIGHT_RESET = 12'd480;
   localparam logic [6:0]  BLOCK_RESET  = 7'd10;

   typedef struct packed {
      logic [11:0] image_width;
      logic [11:0] image_height;
      logic [6:0]  block_size;
   } cfg_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]   sum_red;
      logic [SUM_BITS-1:0]   sum_green;
      logic [SUM_BITS-1:0]   sum_blue;
      logic [COUNT_BITS-1:0] count;
      logic [10:0]           tile_column;
      logic [10:0]           tile_row;
      logic                  frame_done;
   } job_type;

endpackage

FILE: sv/pixel_block_average_mosaic_top.sv
// idle takes a pixel, reads its column sum; update writes it back or waits for the queue
// a tile result goes through the tile queue, the radix-2 divider and the result register
// results queue 4 deep between the accumulator and the divider, so divides overlap pixels
// reset is synchronous: counters clear, registers take 640 / 480 / 10
// the column sum ram is not cleared; the first pixel of each tile overwrites its entry
// ----------------------------------------------------------------------------
// pixel_block_average_mosaic_top
// mosaic tile averager: sums rgb over square tiles and emits one mean per tile
// ----------------------------------------------------------------------------
module pixel_block_average_mosaic_top import pbam_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [1:0]           csr_index,
   input  logic [11:0]          csr_data,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CHAN_BITS-1:0] req_red,
   input  logic [CHAN_BITS-1:0] req_green,
   input  logic [CHAN_BITS-1:0] req_blue,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CHAN_BITS-1:0] rsp_avg_red,
   output logic [CHAN_BITS-1:0] rsp_avg_green,
   output logic [CHAN_BITS-1:0] rsp_avg_blue,
   output logic [10:0]          rsp_tile_column,
   output logic [10:0]          rsp_tile_row,
   output logic                 rsp_frame_done
);

   cfg_type cfg_ff;
   logic    q_push, q_full, q_pop, q_empty;
   job_type push_job, pop_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= WIDTH_RESET;
         cfg_ff.image_height <= HEIGHT_RESET;
         cfg_ff.block_size   <= BLOCK_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_ff.image_width  <= csr_data;
            CSR_IMAGE_HEIGHT: cfg_ff.image_height <= csr_data;
            CSR_BLOCK_SIZE:   cfg_ff.block_size   <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   pbam_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_red  (req_red),
      .req_green(req_green),
      .req_blue (req_blue),
      .q_push   (q_push),
      .q_job    (push_job),
      .q_full   (q_full)
   );

   pbam_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_job(push_job),
      .full    (q_full),
      .pop     (q_pop),
      .pop_job (pop_job),
      .empty   (q_empty)
   );

   pbam_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_job          (pop_job),
      .q_empty        (q_empty),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_avg_red    (rsp_avg_red),
      .rsp_avg_green  (rsp_avg_green),
      .rsp_avg_blue   (rsp_avg_blue),
      .rsp_tile_column(rsp_tile_column),
      .rsp_tile_row   (rsp_tile_row),
      .rsp_frame_done (rsp_frame_done)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full)) else $error("tile queue overflow");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(q_pop && q_empty)) else $error("tile queue underflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty) else $error("result present after reset");

endmodule

FILE: sv/pbam_ram.sv
// ----------------------------------------------------------------------------
// pbam_ram
// generic single-port-write, single-port-read ram with registered read
// ----------------------------------------------------------------------------
module pbam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sv/pbam_front.sv
// ----------------------------------------------------------------------------
// pbam_front
// raster position tracking and per-column tile sum accumulation
// ----------------------------------------------------------------------------
module pbam_front import pbam_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [CHAN_BITS-1:0] req_red,
   input  logic [CHAN_BITS-1:0] req_green,
   input  logic [CHAN_BITS-1:0] req_blue,
   output logic                 q_push,
   output job_type              q_job,
   input  logic                 q_full
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'b01,
      ST_UPDATE = 2'b10
   } state_type;

   state_type state_ff, state_in;

   logic [10:0] pix_col_ff, pix_col_in;
   logic [10:0] pix_row_ff, pix_row_in;
   logic [5:0]  cit_ff, cit_in;
   logic [5:0]  rit_ff, rit_in;
   logic [10:0] tcol_ff, tcol_in;
   logic [10:0] trow_ff, trow_in;

   // latched per pixel
   logic [CHAN_BITS-1:0]  px_r_ff, px_g_ff, px_b_ff;
   logic                  first_ff, tile_end_ff, frame_end_ff;
   logic [SLOT_BITS-1:0]  slot_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [10:0]           job_col_ff, job_row_ff;

   logic [11:0] w_eff, h_eff, w_last, h_last;
   logic [6:0]  bs_eff, bs_last;
   logic        row_end, col_end, tile_x_end, tile_y_end, accept, proceed;
   logic [13:0] count_full;

   logic [3*SUM_BITS-1:0] rd_data, wr_data;
   logic [SUM_BITS-1:0]   new_r, new_g, new_b;

   function automatic logic [SUM_BITS-1:0] sat_add(logic [SUM_BITS-1:0] s,
                                                  logic [CHAN_BITS-1:0] p);
      logic [SUM_BITS:0] t;
      t = {1'b0, s} + {{(SUM_BITS-CHAN_BITS+1){1'b0}}, p};
      return t[SUM_BITS] ? {SUM_BITS{1'b1}} : t[SUM_BITS-1:0];
   endfunction

   always_comb begin
      priority if (cfg.image_width == 12'd0) w_eff = 12'd1;
      else if (cfg.image_width > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
      else w_eff = cfg.image_width;
      priority if (cfg.image_height == 12'd0) h_eff = 12'd1;
      else if (cfg.image_height > 12'(MAX_WIDTH)) h_eff = 12'(MAX_WIDTH);
      else h_eff = cfg.image_height;
      priority if (cfg.block_size == 7'd0) bs_eff = 7'd1;
      else if (cfg.block_size > 7'(MAX_TILE)) bs_eff = 7'(MAX_TILE);
      else bs_eff = cfg.block_size;
   end

   assign w_last     = w_eff - 12'd1;
   assign h_last     = h_eff - 12'd1;
   assign bs_last    = bs_eff - 7'd1;
   assign row_end    = {1'b0, pix_col_ff} >= w_last;
   assign col_end    = {1'b0, pix_row_ff} >= h_last;
   assign tile_x_end = row_end || ({1'b0, cit_ff} >= bs_last);
   assign tile_y_end = col_end || ({1'b0, rit_ff} >= bs_last);
   assign count_full = ({1'b0, cit_ff} + 7'd1) * ({1'b0, rit_ff} + 7'd1);

   assign req_full = (state_ff != ST_IDLE);
   assign accept   = req_push && !req_full;
   assign proceed  = (state_ff == ST_UPDATE) && !(tile_end_ff && q_full);

   always_comb begin
      pix_col_in = pix_col_ff;
      pix_row_in = pix_row_ff;
      cit_in     = cit_ff;
      rit_in     = rit_ff;
      tcol_in    = tcol_ff;
      trow_in    = trow_ff;
      if (accept) begin
         if (row_end) begin
            pix_col_in = '0;
            cit_in     = '0;
            tcol_in    = '0;
            if (col_end) begin
               pix_row_in = '0;
               rit_in     = '0;
               trow_in    = '0;
            end else begin
               pix_row_in = pix_row_ff + 11'd1;
               if ({1'b0, rit_ff} >= bs_last) begin
                  rit_in  = '0;
                  trow_in = trow_ff + 11'd1;
               end else begin
                  rit_in = rit_ff + 6'd1;
               end
            end
         end else begin
            pix_col_in = pix_col_ff + 11'd1;
            if ({1'b0, cit_ff} >= bs_last) begin
               cit_in  = '0;
               tcol_in = tcol_ff + 11'd1;
            end else begin
               cit_in = cit_ff + 6'd1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_UPDATE;
         ST_UPDATE: if (proceed) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pix_col_ff <= '0;
         pix_row_ff <= '0;
         cit_ff     <= '0;
         rit_ff     <= '0;
         tcol_ff    <= '0;
         trow_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         pix_col_ff <= pix_col_in;
         pix_row_ff <= pix_row_in;
         cit_ff     <= cit_in;
         rit_ff     <= rit_in;
         tcol_ff    <= tcol_in;
         trow_ff    <= trow_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_r_ff      <= req_red;
         px_g_ff      <= req_green;
         px_b_ff      <= req_blue;
         first_ff     <= (cit_ff == 6'd0) && (rit_ff == 6'd0);
         tile_end_ff  <= tile_x_end && tile_y_end;
         frame_end_ff <= row_end && col_end;
         slot_ff      <= tcol_ff[SLOT_BITS-1:0];
         count_ff     <= count_full[COUNT_BITS-1:0];
         job_col_ff   <= tcol_ff;
         job_row_ff   <= trow_ff;
      end
   end

   // the first pixel of a tile overwrites the column entry
   assign new_r = first_ff ? {{(SUM_BITS-CHAN_BITS){1'b0}}, px_r_ff}
                           : sat_add(rd_data[SUM_BITS-1:0], px_r_ff);
   assign new_g = first_ff ? {{(SUM_BITS-CHAN_BITS){1'b0}}, px_g_ff}
                           : sat_add(rd_data[2*SUM_BITS-1:SUM_BITS], px_g_ff);
   assign new_b = first_ff ? {{(SUM_BITS-CHAN_BITS){1'b0}}, px_b_ff}
                           : sat_add(rd_data[3*SUM_BITS-1:2*SUM_BITS], px_b_ff);
   assign wr_data = {new_b, new_g, new_r};

   pbam_ram #(
      .WIDTH(3*SUM_BITS),
      .DEPTH(MAX_WIDTH)
   ) u_band_sums (
      .clock  (clock),
      .wr_en  (proceed),
      .wr_addr(slot_ff),
      .wr_data(wr_data),
      .rd_en  (accept),
      .rd_addr(tcol_ff[SLOT_BITS-1:0]),
      .rd_data(rd_data)
   );

   assign q_push = proceed && tile_end_ff;
   always_comb begin
      q_job.sum_red     = new_r;
      q_job.sum_green   = new_g;
      q_job.sum_blue    = new_b;
      q_job.count       = count_ff;
      q_job.tile_column = job_col_ff;
      q_job.tile_row    = job_row_ff;
      q_job.frame_done  = frame_end_ff;
   end

endmodule

FILE: sv/pbam_queue.sv
// ----------------------------------------------------------------------------
// pbam_queue
// short fifo of finished tile sums between front and divider
// ----------------------------------------------------------------------------
module pbam_queue import pbam_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output job_type pop_job,
   output logic    empty
);

   job_type              slots_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_BITS:0]   fill_ff;
   logic                 do_push, do_pop;

   assign full    = (fill_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         fill_ff <= fill_ff + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slots_ff[wr_ptr_ff] <= push_job;
   end

endmodule

FILE: sv/pbam_back.sv
// ----------------------------------------------------------------------------
// pbam_back
// radix-2 divider of the three channel sums and the result register
// ----------------------------------------------------------------------------
module pbam_back import pbam_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  job_type              q_job,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [CHAN_BITS-1:0] rsp_avg_red,
   output logic [CHAN_BITS-1:0] rsp_avg_green,
   output logic [CHAN_BITS-1:0] rsp_avg_blue,
   output logic [10:0]          rsp_tile_column,
   output logic [10:0]          rsp_tile_row,
   output logic                 rsp_frame_done
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_HOLD = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [SUM_BITS-1:0]   quo_ff [3];
   logic [SUM_BITS-1:0]   quo_in [3];
   logic [REM_BITS-1:0]   rem_ff [3];
   logic [REM_BITS-1:0]   rem_in [3];
   logic [COUNT_BITS-1:0] div_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic [10:0]           col_ff, row_ff;
   logic                  done_ff;

   logic                  out_valid_ff;
   logic [CHAN_BITS-1:0]  out_r_ff, out_g_ff, out_b_ff;
   logic [10:0]           out_col_ff, out_row_ff;
   logic                  out_done_ff;

   logic                  out_free, load_out;
   logic [CHAN_BITS-1:0]  mean [3];

   assign out_free = !out_valid_ff || rsp_pop;
   assign q_pop    = (state_ff == ST_IDLE) && !q_empty;
   assign load_out = (state_ff == ST_HOLD) && out_free;

   always_comb begin
      logic [REM_BITS-1:0] trial;
      for (int c = 0; c < 3; c++) begin
         trial     = {rem_ff[c][REM_BITS-2:0], quo_ff[c][SUM_BITS-1]};
         quo_in[c] = {quo_ff[c][SUM_BITS-2:0], 1'b0};
         rem_in[c] = trial;
         if (trial >= div_ff) begin
            rem_in[c]    = trial - div_ff;
            quo_in[c][0] = 1'b1;
         end
         // means above the channel range saturate
         mean[c] = (|quo_ff[c][SUM_BITS-1:CHAN_BITS]) ? {CHAN_BITS{1'b1}}
                                                     : quo_ff[c][CHAN_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (!q_empty) state_in = ST_DIV;
         ST_DIV:  if (step_ff == STEP_BITS'(SUM_BITS-1)) state_in = ST_HOLD;
         ST_HOLD: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) out_valid_ff <= 1'b1;
         else if (rsp_pop) out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         quo_ff[0] <= q_job.sum_red;
         quo_ff[1] <= q_job.sum_green;
         quo_ff[2] <= q_job.sum_blue;
         for (int c = 0; c < 3; c++) rem_ff[c] <= '0;
         div_ff  <= q_job.count;
         step_ff <= '0;
         col_ff  <= q_job.tile_column;
         row_ff  <= q_job.tile_row;
         done_ff <= q_job.frame_done;
      end else if (state_ff == ST_DIV) begin
         for (int c = 0; c < 3; c++) begin
            quo_ff[c] <= quo_in[c];
            rem_ff[c] <= rem_in[c];
         end
         step_ff <= step_ff + 1'b1;
      end
      if (load_out) begin
         out_r_ff    <= mean[0];
         out_g_ff    <= mean[1];
         out_b_ff    <= mean[2];
         out_col_ff  <= col_ff;
         out_row_ff  <= row_ff;
         out_done_ff <= done_ff;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_avg_red     = out_r_ff;
   assign rsp_avg_green   = out_g_ff;
   assign rsp_avg_blue    = out_b_ff;
   assign rsp_tile_column = out_col_ff;
   assign rsp_tile_row    = out_row_ff;
   assign rsp_frame_done  = out_done_ff;

endmodule

FILE: bench/tb_pixel_block_average_mosaic_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pixel_block_average_mosaic_top
// streams raster pixels through the mosaic averager under several tile and
// image settings, predicts every tile mean and compares it field by field
// ----------------------------------------------------------------------------
module tb_pixel_block_average_mosaic_top;
   import pbam_pkg::*;

   typedef struct {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [10:0] column;
      logic [10:0] row;
      logic        done;
   } tile_mean_type;

   class tile_mean_board;
      int unsigned   width_reg;
      int unsigned   height_reg;
      int unsigned   block_reg;
      int unsigned   col_sums [MAX_WIDTH][3];
      int unsigned   px_col, px_row, col_in, row_in, tile_col, tile_row;
      tile_mean_type pending[$];
      int            errors;

      function void clear();
         width_reg = WIDTH_RESET;
         height_reg = HEIGHT_RESET;
         block_reg = BLOCK_RESET;
         px_col = 0; px_row = 0; col_in = 0; row_in = 0; tile_col = 0; tile_row = 0;
         pending.delete();
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [11:0] value);
         case (idx)
            CSR_IMAGE_WIDTH:  width_reg = value;
            CSR_IMAGE_HEIGHT: height_reg = value;
            CSR_BLOCK_SIZE:   block_reg = value[6:0];
            default: ;
         endcase
      endfunction

      function int unsigned limit_to(int unsigned v, int unsigned hi);
         if (v == 0) return 1;
         if (v > hi) return hi;
         return v;
      endfunction

      // one accepted request: update the column sums and queue a tile mean if one closes
      function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
         int unsigned w, h, bs, slot, cnt, s, q;
         int unsigned px[3];
         bit first, row_end, col_end, x_end, y_end;
         tile_mean_type t;
         w = limit_to(width_reg, MAX_WIDTH);
         h = limit_to(height_reg, MAX_WIDTH);
         bs = limit_to(block_reg, MAX_TILE);
         slot = tile_col % MAX_WIDTH;
         first = (col_in == 0) && (row_in == 0);
         row_end = px_col >= w - 1;
         col_end = px_row >= h - 1;
         x_end = row_end || col_in >= bs - 1;
         y_end = col_end || row_in >= bs - 1;
         px[0] = r; px[1] = g; px[2] = b;
         for (int c = 0; c < 3; c++) begin
            if (first) begin
               col_sums[slot][c] = px[c];
            end else begin
               s = col_sums[slot][c] + px[c];
               col_sums[slot][c] = (s > 20'hFFFFF) ? 20'hFFFFF : s;
            end
         end
         if (x_end && y_end) begin
            cnt = (col_in + 1) * (row_in + 1);
            q = col_sums[slot][0] / cnt; t.red = (q > 255) ? 8'hFF : q[7:0];
            q = col_sums[slot][1] / cnt; t.green = (q > 255) ? 8'hFF : q[7:0];
            q = col_sums[slot][2] / cnt; t.blue = (q > 255) ? 8'hFF : q[7:0];
            t.column = tile_col[10:0];
            t.row = tile_row[10:0];
            t.done = row_end && col_end;
            pending = {pending, t};
         end
         if (row_end) begin
            px_col = 0; col_in = 0; tile_col = 0;
            if (col_end) begin
               px_row = 0; row_in = 0; tile_row = 0;
            end else begin
               px_row++;
               if (row_in >= bs - 1) begin
                  row_in = 0;
                  tile_row++;
               end else begin
                  row_in++;
               end
            end
         end else begin
            px_col++;
            if (col_in >= bs - 1) begin
               col_in = 0;
               tile_col++;
            end else begin
               col_in++;
            end
         end
      endfunction

      function void check_tile(tile_mean_type got);
         tile_mean_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected tile mean col %0d row %0d", $time, got.column, got.row);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.red !== want.red) begin
            $display("%0t: avg_red expected %0d actual %0d", $time, want.red, got.red);
            errors++;
         end
         if (got.green !== want.green) begin
            $display("%0t: avg_green expected %0d actual %0d", $time, want.green, got.green);
            errors++;
         end
         if (got.blue !== want.blue) begin
            $display("%0t: avg_blue expected %0d actual %0d", $time, want.blue, got.blue);
            errors++;
         end
         if (got.column !== want.column) begin
            $display("%0t: tile_column expected %0d actual %0d", $time, want.column,
                     got.column);
            errors++;
         end
         if (got.row !== want.row) begin
            $display("%0t: tile_row expected %0d actual %0d", $time, want.row, got.row);
            errors++;
         end
         if (got.done !== want.done) begin
            $display("%0t: frame_done expected %0b actual %0b", $time, want.done, got.done);
            errors++;
         end
      endfunction
   endclass

   logic             clock;
   logic             reset;
   logic             csr_write;
   logic [1:0]       csr_index;
   logic [11:0]      csr_data;
   logic             req_push;
   logic             req_full;
   logic [7:0]       req_red, req_green, req_blue;
   logic             rsp_empty;
   logic             rsp_pop;
   logic [7:0]       rsp_avg_red, rsp_avg_green, rsp_avg_blue;
   logic [10:0]      rsp_tile_column, rsp_tile_row;
   logic             rsp_frame_done;

   tile_mean_board   board;
   bit               long_hold;
   int               burst_left;
   int               random_sent;

   pixel_block_average_mosaic_top uut (
      .clock(clock), .reset(reset),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_push(req_push), .req_full(req_full),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop),
      .rsp_avg_red(rsp_avg_red), .rsp_avg_green(rsp_avg_green),
      .rsp_avg_blue(rsp_avg_blue), .rsp_tile_column(rsp_tile_column),
      .rsp_tile_row(rsp_tile_row), .rsp_frame_done(rsp_frame_done)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb_pixel_block_average_mosaic_top: FAIL");
      $finish;
   end

   // result side: stall pattern of its own, plus a long hold-off on request
   initial begin
      int mode;
      rsp_pop = 1'b0;
      mode = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_pop <= 1'b0;
            repeat (400) @(posedge clock);
            long_hold = 1'b0;
         end
         if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 2);
         case (mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= 1'($urandom_range(0, 1));
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      tile_mean_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.red = rsp_avg_red;
         got.green = rsp_avg_green;
         got.blue = rsp_avg_blue;
         got.column = rsp_tile_column;
         got.row = rsp_tile_row;
         got.done = rsp_frame_done;
         board.check_tile(got);
      end
   end

   task automatic push_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      req_push <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (req_full);
      board.note_pixel(r, g, b);
   endtask

   // burst sender: random gaps between bursts of random length
   task automatic send_random(int count);
      int gap;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
               req_push <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         burst_left--;
         push_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)));
         random_sent++;
      end
      req_push <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every tile mean, then for the divider to drain
   task automatic drain();
      req_push <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [11:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.set_reg(idx, value);
   endtask

   task automatic set_image(logic [11:0] w, logic [11:0] h, logic [6:0] bs);
      drain();
      write_reg(CSR_IMAGE_WIDTH, w);
      write_reg(CSR_IMAGE_HEIGHT, h);
      write_reg(CSR_BLOCK_SIZE, {5'd0, bs});
   endtask

   initial begin
      int pick;
      board = new();
      board.clear();
      long_hold = 1'b0;
      burst_left = 0;
      random_sent = 0;
      reset <= 1'b1;
      csr_write <= 1'b0;
      csr_index <= CSR_IMAGE_WIDTH;
      csr_data <= '0;
      req_push <= 1'b0;
      req_red <= '0;
      req_green <= '0;
      req_blue <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: a few pixels, no tile closes
      for (int i = 0; i < 8; i++) push_pixel(8'hFF, 8'h00, 8'hA5);
      req_push <= 1'b0;

      // 1x1 tiles along the start of a row: oversized width, zero height and block
      set_image(12'hFFF, 12'd0, 7'd0);
      send_random(32);
      send_random(8);

      // oversized block clipped to a 3x2 image
      set_image(12'd3, 12'd2, 7'h7F);
      push_pixel(8'hFF, 8'hFF, 8'hFF);
      push_pixel(8'h00, 8'h00, 8'h00);
      push_pixel(8'hFF, 8'h00, 8'h80);
      push_pixel(8'h01, 8'hFE, 8'h7F);
      push_pixel(8'hFF, 8'hFF, 8'h00);
      push_pixel(8'h00, 8'hFF, 8'hFF);
      req_push <= 1'b0;

      // 4x4 image in 3x3 tiles: full, right-clipped, bottom-clipped and corner tiles
      set_image(12'd4, 12'd4, 7'd3);
      for (int i = 0; i < 16; i++)
         push_pixel((i % 2) ? 8'hFF : 8'h00, (i % 3) ? 8'h55 : 8'hAA, i[7:0] * 8'd17);
      req_push <= 1'b0;

      // hold the result side off while 1x1 tiles flood the block
      set_image(12'd16, 12'd16, 7'd1);
      long_hold = 1'b1;
      send_random(80);

      // position kept across a shrink of the image and the tile mid-frame
      set_image(12'd12, 12'd10, 7'd4);
      send_random(30);
      set_image(12'd5, 12'd3, 7'd2);
      send_random(40);

      while (random_sent < 370) begin
         pick = $urandom_range(0, 19);
         drain();
         if (pick < 14) begin
            write_reg(CSR_IMAGE_WIDTH, 12'($urandom_range(1, 24)));
            write_reg(CSR_IMAGE_HEIGHT, 12'($urandom_range(1, 12)));
            write_reg(CSR_BLOCK_SIZE, 12'($urandom_range(1, 8)));
         end else if (pick < 16) begin
            write_reg(CSR_IMAGE_WIDTH, 12'($urandom_range(60, 140)));
            write_reg(CSR_IMAGE_HEIGHT, 12'($urandom_range(1, 3)));
            write_reg(CSR_BLOCK_SIZE, $urandom_range(0, 1) ? 12'd64 : 12'h07F);
         end else if (pick < 18) begin
            // a single register changes while the frame is under way
            write_reg(2'($urandom_range(0, 2)), 12'($urandom_range(0, 9)));
         end else begin
            write_reg(CSR_IMAGE_WIDTH, $urandom_range(0, 1) ? 12'd0 : 12'd1);
            write_reg(CSR_IMAGE_HEIGHT, $urandom_range(0, 1) ? 12'd0 : 12'hFFF);
            write_reg(CSR_BLOCK_SIZE, 12'($urandom_range(0, 2)));
         end
         send_random($urandom_range(20, 60));
      end

      drain();
      if (board.errors == 0) begin
         $display("tb_pixel_block_average_mosaic_top: PASS");
      end else begin
         $display("tb_pixel_block_average_mosaic_top: FAIL");
      end
      $finish;
   end

endmodule
